[sv/aluf_pkg.sv]
// Shared types and constants for the accumulator ALU with flags.
// Depends on nothing; imported by the top level.
`default_nettype none

package aluf_pkg;

  localparam int unsigned DataWidth = 8;
  localparam int unsigned KindWidth = 4;

  typedef logic [DataWidth-1:0] data_t;

  // Operation codes carried in the kind field.
  typedef enum logic [KindWidth-1:0] {
    KIND_ADC = 4'd0,
    KIND_SBC = 4'd1,
    KIND_CMP = 4'd2,
    KIND_CPX = 4'd3,
    KIND_CPY = 4'd4,
    KIND_INC = 4'd5,
    KIND_DEC = 4'd6,
    KIND_INX = 4'd7,
    KIND_INY = 4'd8,
    KIND_DEX = 4'd9,
    KIND_DEY = 4'd10,
    KIND_CLC = 4'd11,
    KIND_SEC = 4'd12,
    KIND_CLD = 4'd13,
    KIND_SED = 4'd14,
    KIND_CLV = 4'd15
  } kind_t;

  // Processor status flags.
  typedef struct packed {
    logic carry;
    logic zero;
    logic negative;
    logic overflow;
    logic decimal;
  } flags_t;

endpackage : aluf_pkg

`default_nettype wire

[sv/accumulator_alu_with_flags.sv]
// Top level of the accumulator ALU: A, X, Y and status flags with one result per item.
// Depends on aluf_pkg for the operation codes, data and flag types.
// Pipeline: an accepted transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while result_ready does not hold the result register.
// Reset: rst clears A, X, Y, all flags and both valid stages; payload registers are not reset.
`default_nettype none

module accumulator_alu_with_flags
  import aluf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // Operation channel.
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire logic [3:0] kind,
  input  wire logic [7:0] operand,
  // Result channel.
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [7:0]      acc_out,
  output logic [7:0]      x_out,
  output logic [7:0]      y_out,
  output logic [7:0]      mem_result,
  output logic            mem_write,
  output logic            carry_out,
  output logic            zero_out,
  output logic            negative_out,
  output logic            overflow_out,
  output logic            decimal_out
);

  // Input register stage.
  logic   s1_valid;
  kind_t  s1_kind;
  data_t  s1_operand;

  // Architectural state.
  data_t  accumulator;
  data_t  index_x;
  data_t  index_y;
  flags_t flags;

  // Next values computed from the input register and the state.
  data_t  accumulator_next;
  data_t  index_x_next;
  data_t  index_y_next;
  flags_t flags_next;
  data_t  mem_next;
  logic   mem_write_next;

  logic   advance;

  // The result register takes a new transaction when empty or being drained.
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      s1_kind    <= kind_t'(kind);
      s1_operand <= operand;
    end
  end

  // Adder shared by ADC and SBC; SBC feeds the inverted operand.
  data_t                addend;
  logic [DataWidth:0]   sum;
  // Subtractor for the three compares.
  data_t                cmp_reg;
  logic [DataWidth:0]   diff;
  // Memory and index steppers.
  data_t                mem_inc;
  data_t                mem_dec;
  data_t                x_inc;
  data_t                x_dec;
  data_t                y_inc;
  data_t                y_dec;

  always_comb begin
    addend = (s1_kind == KIND_SBC) ? ~s1_operand : s1_operand;
    sum    = {1'b0, accumulator} + {1'b0, addend} + {{DataWidth{1'b0}}, flags.carry};

    priority if (s1_kind == KIND_CPX) begin
      cmp_reg = index_x;
    end else if (s1_kind == KIND_CPY) begin
      cmp_reg = index_y;
    end else begin
      cmp_reg = accumulator;
    end
    diff = {1'b0, cmp_reg} - {1'b0, s1_operand};

    mem_inc = s1_operand + data_t'(1);
    mem_dec = s1_operand - data_t'(1);
    x_inc   = index_x + data_t'(1);
    x_dec   = index_x - data_t'(1);
    y_inc   = index_y + data_t'(1);
    y_dec   = index_y - data_t'(1);
  end

  // Operation decode: next registers, flags and the store-back byte.
  always_comb begin
    accumulator_next = accumulator;
    index_x_next     = index_x;
    index_y_next     = index_y;
    flags_next       = flags;
    mem_next         = '0;
    mem_write_next   = 1'b0;

    unique case (s1_kind)
      KIND_ADC, KIND_SBC: begin
        accumulator_next    = sum[DataWidth-1:0];
        flags_next.carry    = sum[DataWidth];
        flags_next.overflow = ~(accumulator[DataWidth-1] ^ addend[DataWidth-1]) &
                              (accumulator[DataWidth-1] ^ sum[DataWidth-1]);
        flags_next.zero     = (sum[DataWidth-1:0] == '0);
        flags_next.negative = sum[DataWidth-1];
      end
      KIND_CMP, KIND_CPX, KIND_CPY: begin
        flags_next.carry    = ~diff[DataWidth];
        flags_next.zero     = (cmp_reg == s1_operand);
        flags_next.negative = diff[DataWidth-1];
      end
      KIND_INC: begin
        mem_next            = mem_inc;
        mem_write_next      = 1'b1;
        flags_next.zero     = (mem_inc == '0);
        flags_next.negative = mem_inc[DataWidth-1];
      end
      KIND_DEC: begin
        mem_next            = mem_dec;
        mem_write_next      = 1'b1;
        flags_next.zero     = (mem_dec == '0);
        flags_next.negative = mem_dec[DataWidth-1];
      end
      KIND_INX: begin
        index_x_next        = x_inc;
        flags_next.zero     = (x_inc == '0);
        flags_next.negative = x_inc[DataWidth-1];
      end
      KIND_INY: begin
        index_y_next        = y_inc;
        flags_next.zero     = (y_inc == '0);
        flags_next.negative = y_inc[DataWidth-1];
      end
      KIND_DEX: begin
        index_x_next        = x_dec;
        flags_next.zero     = (x_dec == '0);
        flags_next.negative = x_dec[DataWidth-1];
      end
      KIND_DEY: begin
        index_y_next        = y_dec;
        flags_next.zero     = (y_dec == '0);
        flags_next.negative = y_dec[DataWidth-1];
      end
      KIND_CLC: flags_next.carry    = 1'b0;
      KIND_SEC: flags_next.carry    = 1'b1;
      KIND_CLD: flags_next.decimal  = 1'b0;
      KIND_SED: flags_next.decimal  = 1'b1;
      KIND_CLV: flags_next.overflow = 1'b0;
      default: begin
        accumulator_next = accumulator;
      end
    endcase
  end

  // State update and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      index_x      <= '0;
      index_y      <= '0;
      flags        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        accumulator  <= accumulator_next;
        index_x      <= index_x_next;
        index_y      <= index_y_next;
        flags        <= flags_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (advance) begin
      acc_out      <= accumulator_next;
      x_out        <= index_x_next;
      y_out        <= index_y_next;
      mem_result   <= mem_next;
      mem_write    <= mem_write_next;
      carry_out    <= flags_next.carry;
      zero_out     <= flags_next.zero;
      negative_out <= flags_next.negative;
      overflow_out <= flags_next.overflow;
      decimal_out  <= flags_next.decimal;
    end
  end

`ifndef SYNTHESIS
  // A shown result always matches the live register file.
  a_regs_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (acc_out == accumulator && x_out == index_x && y_out == index_y))
    else $error("result registers differ from the register file");

  // Flags shown with a result match the live status flags.
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (carry_out == flags.carry && zero_out == flags.zero &&
                      negative_out == flags.negative && overflow_out == flags.overflow &&
                      decimal_out == flags.decimal))
    else $error("result flags differ from the status register");

  // A store-back byte drives zero and negative; without a store it reads zero.
  a_mem_flags: assert property (@(posedge clk) disable iff (rst)
    (result_valid && mem_write) |-> (zero_out == (mem_result == '0) &&
                                     negative_out == mem_result[DataWidth-1]))
    else $error("memory result and its flags disagree");

  a_mem_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !mem_write) |-> (mem_result == '0))
    else $error("memory result nonzero without a store");

  // State changes only when a transaction moves into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(accumulator) && $stable(index_x) && $stable(index_y) &&
                  $stable(flags)))
    else $error("state changed without a transaction");
`endif

endmodule : accumulator_alu_with_flags

`default_nettype wire
